>>> src/c3sa_pkg.sv
package c3sa_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 48;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 12;
    localparam int COL_IDX_W  = $clog2(MAX_WIDTH);
    localparam int FILL_W     = $clog2(MAX_WIDTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int ROW_W      = PROD_W + 2;
    localparam int TOT_W      = SUM_W + 2;
    localparam int MIN_WIDTH  = 3;

    // 48-bit signed bounds, held at the width of the full total
    localparam logic signed [TOT_W-1:0] TOT_MAX =
        {{(TOT_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
    localparam logic signed [TOT_W-1:0] TOT_MIN = ~TOT_MAX;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_WEIGHT_TOP  = 2'd1,
        CFG_WEIGHT_MID  = 2'd2,
        CFG_WEIGHT_BOT  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic signed [SUM_W-1:0] partial_in;
        logic                    start_of_plane;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic [COL_W-1:0]        out_col;
        logic                    saturated;
    } t_out_item;

endpackage

>>> src/conv3x3_stream_accumulate_unit.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------------
// in       | in        | i_in_valid / o_in_ready   | i_in_data  (c3sa_pkg::t_in_item)
// out      | out       | o_out_valid / i_out_ready | o_out_data (c3sa_pkg::t_out_item)
// cfg      | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// One item per cycle while the output takes results; each item uses the line store
// read port once, at accept. A taken item passes the line store read, products, row
// sums and total registers, and saturation feeds the output register.
// Items that complete no window (row or column below two) leave no result.
// Stalls back up stage by stage, so items keep being taken until the pipe is full.
// Reset is synchronous; no clearing pass: a fill count marks line store entries
// never written since reset, which read as zero.
module conv3x3_stream_accumulate_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  c3sa_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output c3sa_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [c3sa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [c3sa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PIX_W  = c3sa_pkg::PIX_W;
    localparam int SUM_W  = c3sa_pkg::SUM_W;
    localparam int CI_W   = c3sa_pkg::COL_IDX_W;
    localparam int FILL_W = c3sa_pkg::FILL_W;
    localparam int PROD_W = c3sa_pkg::PROD_W;
    localparam int ROW_W  = c3sa_pkg::ROW_W;
    localparam int TOT_W  = c3sa_pkg::TOT_W;

    // ---------------- configuration ----------------
    logic [c3sa_pkg::WIDTH_W-1:0] r_width;
    logic [SUM_W-1:0]             r_wrow [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= c3sa_pkg::WIDTH_W'(c3sa_pkg::MAX_WIDTH);
            for (int i = 0; i < 3; i++) r_wrow[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (c3sa_pkg::t_cfg_reg'(i_cfg_idx))
                c3sa_pkg::CFG_IMAGE_WIDTH: r_width  <= i_cfg_data[c3sa_pkg::WIDTH_W-1:0];
                c3sa_pkg::CFG_WEIGHT_TOP:  r_wrow[0] <= i_cfg_data[SUM_W-1:0];
                c3sa_pkg::CFG_WEIGHT_MID:  r_wrow[1] <= i_cfg_data[SUM_W-1:0];
                c3sa_pkg::CFG_WEIGHT_BOT:  r_wrow[2] <= i_cfg_data[SUM_W-1:0];
            endcase
        end
    end

    // width clamped into the supported range
    logic [c3sa_pkg::WIDTH_W-1:0] eff_w;
    always_comb begin
        if (int'(r_width) < c3sa_pkg::MIN_WIDTH)
            eff_w = c3sa_pkg::WIDTH_W'(c3sa_pkg::MIN_WIDTH);
        else if (int'(r_width) > c3sa_pkg::MAX_WIDTH)
            eff_w = c3sa_pkg::WIDTH_W'(c3sa_pkg::MAX_WIDTH);
        else
            eff_w = r_width;
    end

    // ---------------- stage handshakes ----------------
    logic r_a_valid, r_p_valid, r_s_valid, r_t_valid, r_out_valid;
    logic r_a_produce;
    logic adv_out, en_t, en_s, en_p, a_adv, accept;

    assign adv_out    = !r_out_valid || i_out_ready;
    assign en_t       = !r_t_valid || adv_out;
    assign en_s       = !r_s_valid || en_t;
    assign en_p       = !r_p_valid || en_s;
    assign a_adv      = r_a_valid && (!r_a_produce || en_p);
    assign o_in_ready = !r_a_valid || a_adv;
    assign accept     = i_in_valid && o_in_ready;

    // ---------------- position counters ----------------
    logic [CI_W-1:0] r_col, cur_col, n_col;
    logic [1:0]      r_row, cur_row, n_row;
    logic            cur_produce;

    always_comb begin
        cur_col     = i_in_data.start_of_plane ? '0 : r_col;
        cur_row     = i_in_data.start_of_plane ? '0 : r_row;
        cur_produce = (cur_row >= 2'd2) && (int'(cur_col) >= 2);
        if (int'(cur_col) + 1 >= int'(eff_w)) begin
            n_col = '0;
            n_row = (cur_row < 2'd2) ? cur_row + 2'd1 : cur_row;
        end else begin
            n_col = cur_col + CI_W'(1);
            n_row = cur_row;
        end
    end

    // ---------------- line stores ----------------
    logic [PIX_W-1:0] line_a [c3sa_pkg::MAX_WIDTH];
    logic [PIX_W-1:0] line_b [c3sa_pkg::MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_a, r_rd_b;
    logic [FILL_W-1:0] r_fill;

    // stage A: item waiting for its line store data
    logic signed [PIX_W-1:0] r_a_px;
    logic signed [SUM_W-1:0] r_a_partial;
    logic [CI_W-1:0]         r_a_col;
    logic                    r_a_rdok, r_a_fwd;
    logic [PIX_W-1:0]        r_a_fpx, r_a_fup1;
    logic [PIX_W-1:0]        up1, up2;

    always_comb begin
        if (r_a_fwd) begin
            up1 = r_a_fpx;
            up2 = r_a_fup1;
        end else begin
            up1 = r_a_rdok ? r_rd_a : '0;
            up2 = r_a_rdok ? r_rd_b : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a <= line_a[cur_col];
            r_rd_b <= line_b[cur_col];
        end
        if (a_adv) begin
            line_a[r_a_col] <= r_a_px;
            line_b[r_a_col] <= up1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_fill      <= '0;
            r_a_valid   <= 1'b0;
            r_a_produce <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            // columns are always written as a prefix from zero
            if (a_adv && ({1'b0, r_a_col} == r_fill[CI_W:0]))
                r_fill <= r_fill + FILL_W'(1);
            if (o_in_ready) begin
                r_a_valid   <= i_in_valid;
                r_a_produce <= i_in_valid && cur_produce;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px      <= i_in_data.pixel;
            r_a_partial <= i_in_data.partial_in;
            r_a_col     <= cur_col;
            r_a_rdok    <= int'(cur_col) < int'(r_fill);
            // same entry written by the item leaving stage A this edge
            r_a_fwd     <= a_adv && (r_a_col == cur_col);
            r_a_fpx     <= r_a_px;
            r_a_fup1    <= up1;
        end
    end

    // ---------------- window and products ----------------
    logic signed [PIX_W-1:0]  r_win [3][3];
    logic signed [PIX_W-1:0]  n_win [3][3];
    logic signed [PIX_W-1:0]  wgt   [3][3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [SUM_W-1:0]  r_p_partial;
    logic [CI_W-1:0]          r_p_col;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
            for (int c = 0; c < 3; c++)
                wgt[r][c] = r_wrow[r][PIX_W*c +: PIX_W];
        end
        n_win[0][2] = up2;
        n_win[1][2] = up1;
        n_win[2][2] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) r_win <= n_win;
        if (a_adv && r_a_produce) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    r_prod[r][c] <= n_win[r][c] * wgt[r][c];
            r_p_partial <= r_a_partial;
            r_p_col     <= r_a_col - CI_W'(2);
        end
    end

    // ---------------- row sums, total ----------------
    logic signed [ROW_W-1:0] r_rsum [3];
    logic signed [SUM_W-1:0] r_s_partial;
    logic [CI_W-1:0]         r_s_col;
    logic signed [TOT_W-1:0] r_tot;
    logic [CI_W-1:0]         r_t_col;

    always_ff @(posedge i_clk) begin
        if (en_s && r_p_valid) begin
            for (int r = 0; r < 3; r++)
                r_rsum[r] <= ROW_W'(r_prod[r][0]) + ROW_W'(r_prod[r][1])
                           + ROW_W'(r_prod[r][2]);
            r_s_partial <= r_p_partial;
            r_s_col     <= r_p_col;
        end
        if (en_t && r_s_valid) begin
            r_tot   <= TOT_W'(r_s_partial) + TOT_W'(r_rsum[0]) + TOT_W'(r_rsum[1])
                     + TOT_W'(r_rsum[2]);
            r_t_col <= r_s_col;
        end
    end

    // ---------------- saturation and output register ----------------
    c3sa_pkg::t_out_item r_out, n_out;

    always_comb begin
        n_out.out_col = c3sa_pkg::COL_W'(r_t_col);
        if (r_tot > c3sa_pkg::TOT_MAX) begin
            n_out.conv_sum  = c3sa_pkg::TOT_MAX[SUM_W-1:0];
            n_out.saturated = 1'b1;
        end else if (r_tot < c3sa_pkg::TOT_MIN) begin
            n_out.conv_sum  = c3sa_pkg::TOT_MIN[SUM_W-1:0];
            n_out.saturated = 1'b1;
        end else begin
            n_out.conv_sum  = r_tot[SUM_W-1:0];
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_t_valid) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_t_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_p)    r_p_valid   <= a_adv && r_a_produce;
            if (en_s)    r_s_valid   <= r_p_valid;
            if (en_t)    r_t_valid   <= r_s_valid;
            if (adv_out) r_out_valid <= r_t_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= c3sa_pkg::MAX_WIDTH)
        else $error("fill count beyond store depth");

    a_col_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (int'(r_a_col) <= int'(r_fill)))
        else $error("stage A column outside written prefix");

    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row != 2'd3)
        else $error("row count passed two");

    a_produce_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_produce) |-> (int'(r_a_col) >= 2))
        else $error("window result before column two");

    a_total_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t_valid && !adv_out) |=> (r_t_valid && $stable(r_tot)))
        else $error("total lost while output stalled");
`endif

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3sa_pkg::*;

    // A run ends in failure once this many cycles pass without any item moving.
    // The longest quiet stretch in a correct run is the long receiver hold-off
    // plus the pipeline depth, far below this.
    localparam int QUIET_LIMIT   = 4000;
    // Margin for the pipe to clear before touching registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RESET_CYCLES  = 11;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam logic [PIX_W-1:0] PIX_MOST_NEG = 16'h8000;
    localparam logic [PIX_W-1:0] PIX_MOST_POS = 16'h7FFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic {
        STEP_REG,
        STEP_PIXEL
    } t_step_kind;

    // One row of the directed table: either a register write or a pixel,
    // the latter optionally carrying a result typed in by hand.
    typedef struct packed {
        t_step_kind            kind;
        t_cfg_reg              reg_idx;
        logic [CFG_DATA_W-1:0] reg_value;
        t_in_item              item;
        bit                    typed;
        t_out_item             result;
    } t_directed_step;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    t_cfg_reg              cfg_idx   = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Idling controls, set per phase by the stimulus
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int unsigned hold_left      = 0;

    t_out_item      expected_sums[$];
    t_directed_step directed_steps[$];
    int unsigned    mismatches   = 0;
    int unsigned    quiet_cycles = 0;

    // Shadow of the block: registers, line stores, window and counters
    logic [WIDTH_W-1:0] width_reg;
    logic [SUM_W-1:0]   weight_rows [3];
    logic [PIX_W-1:0]   line_prev   [MAX_WIDTH];
    logic [PIX_W-1:0]   line_prev2  [MAX_WIDTH];
    logic [PIX_W-1:0]   pix_window  [3][3];
    int unsigned        col_cnt;
    int unsigned        row_cnt;

    conv3x3_stream_accumulate_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off counted here once requested
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid === 1'b1 && out_ready) begin
            if (expected_sums.size() == 0) begin
                $error("unexpected result: conv_sum %0d out_col %0d saturated %0b",
                       out_item.conv_sum, out_item.out_col, out_item.saturated);
                mismatches++;
            end else begin
                want = expected_sums.pop_front();
                if (out_item.conv_sum !== want.conv_sum) begin
                    $error("conv_sum: expected %0d, got %0d",
                           want.conv_sum, out_item.conv_sum);
                    mismatches++;
                end
                if (out_item.out_col !== want.out_col) begin
                    $error("out_col: expected %0d, got %0d",
                           want.out_col, out_item.out_col);
                    mismatches++;
                end
                if (out_item.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, out_item.saturated);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("conv3x3_stream_accumulate_unit regression: fail");
            $finish;
        end
    end

    // Shadow step for one accepted pixel. Mirrors the line store rotation and
    // window shift, then forms the exact sum of nine Q10.22 products plus the
    // incoming partial, clipped to 48 signed bits.
    task automatic step_window(input t_in_item item, output bit fired,
                               output t_out_item res);
        int unsigned   eff_w;
        int unsigned   col;
        logic [15:0]   up1;
        logic [15:0]   up2;
        longint        acc;
        bit            sat;
        if (item.start_of_plane) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // out-of-range widths clamp to the legal span
        eff_w = width_reg;
        if (eff_w < MIN_WIDTH) eff_w = MIN_WIDTH;
        if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
        col = col_cnt;
        if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;

        up1 = line_prev[col];
        up2 = line_prev2[col];
        for (int r = 0; r < 3; r++) begin
            pix_window[r][0] = pix_window[r][1];
            pix_window[r][1] = pix_window[r][2];
        end
        pix_window[0][2] = up2;
        pix_window[1][2] = up1;
        pix_window[2][2] = item.pixel;
        line_prev2[col]  = up1;
        line_prev[col]   = item.pixel;

        fired = 1'b0;
        res   = '0;
        if (row_cnt >= 2 && col >= 2) begin
            acc = $signed(item.partial_in);
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    acc += longint'($signed(weight_rows[r][16*c +: 16]))
                         * longint'($signed(pix_window[r][c]));
                end
            end
            sat = 1'b0;
            if (acc > longint'(SUM_MAX)) begin
                acc = SUM_MAX;
                sat = 1'b1;
            end
            if (acc < longint'(SUM_MIN)) begin
                acc = SUM_MIN;
                sat = 1'b1;
            end
            res.conv_sum  = acc[SUM_W-1:0];
            res.out_col   = COL_W'(col - 2);
            res.saturated = sat;
            fired         = 1'b1;
        end

        // a row ends once the column reaches width-1 or beyond, so a width
        // shrunk mid-row wraps at once
        if (col + 1 >= eff_w) begin
            col_cnt = 0;
            if (row_cnt < 2) row_cnt++;
        end else begin
            col_cnt = col + 1;
        end
    endtask

    // Offer one item, called and returning at a falling edge. Valid is not
    // lowered after acceptance; the next call or the settle task decides.
    task automatic send_item(input t_in_item item, input bit typed,
                             input t_out_item typed_result);
        bit        fired;
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        step_window(item, fired, res);
        if (typed)
            expected_sums.push_back(typed_result);
        else if (fired)
            expected_sums.push_back(res);
        @(negedge i_clk);
    endtask

    // Stop offering, let every expected result arrive, then give items that
    // leave no result time to clear the pipe.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = value[WIDTH_W-1:0];
        else
            weight_rows[int'(idx) - 1] = value;
    endtask

    function automatic void add_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        t_directed_step s;
        s           = '0;
        s.kind      = STEP_REG;
        s.reg_idx   = idx;
        s.reg_value = value;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_pixel(input bit start, input logic [PIX_W-1:0] pix,
                                      input logic [SUM_W-1:0] partial);
        t_directed_step s;
        s                     = '0;
        s.kind                = STEP_PIXEL;
        s.item.start_of_plane = start;
        s.item.pixel          = pix;
        s.item.partial_in     = partial;
        directed_steps.push_back(s);
    endfunction

    // Pixel whose result is known by inspection; width three, so column zero
    function automatic void add_checked(input logic [PIX_W-1:0] pix,
                                        input logic [SUM_W-1:0] partial,
                                        input logic [SUM_W-1:0] sum, input bit sat);
        t_directed_step s;
        s                  = '0;
        s.kind             = STEP_PIXEL;
        s.item.pixel       = pix;
        s.item.partial_in  = partial;
        s.typed            = 1'b1;
        s.result.conv_sum  = sum;
        s.result.saturated = sat;
        directed_steps.push_back(s);
    endfunction

    function automatic logic [SUM_W-1:0] pick_weights();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       return '0;
            1:       return {3{PIX_MOST_NEG}};
            2:       return {3{PIX_MOST_POS}};
            default: return r[SUM_W-1:0];
        endcase
    endfunction

    function automatic t_in_item pick_item(input bit allow_start);
        t_in_item    item;
        logic [63:0] r;
        r = {$urandom, $urandom};
        item.start_of_plane = allow_start && ($urandom_range(63) == 0);
        case ($urandom_range(7))
            0:       item.pixel = PIX_MOST_NEG;
            1:       item.pixel = PIX_MOST_POS;
            2:       item.pixel = '0;
            default: item.pixel = r[63:48];
        endcase
        // partials close to either bound make clipping frequent
        case ($urandom_range(4))
            0:       item.partial_in = SUM_MAX - $urandom;
            1:       item.partial_in = SUM_MIN + $urandom;
            2:       item.partial_in = {{(SUM_W - 16){r[15]}}, r[15:0]};
            default: item.partial_in = r[SUM_W-1:0];
        endcase
        return item;
    endfunction

    // One random phase: fresh registers, an idling pattern, a run of pixels.
    // With pressure set, the receiver holds off for a long stretch while items
    // keep coming, and halfway the sender waits for the pipe to drain.
    task automatic run_phase(input logic [WIDTH_W-1:0] width, input t_idle_mode mode,
                             input int unsigned count, input bit allow_start,
                             input bit pressure);
        t_out_item none;
        none = '0;
        settle();
        write_reg(CFG_IMAGE_WIDTH, width);
        for (int r = 1; r <= 3; r++)
            write_reg(t_cfg_reg'(r), pick_weights());
        send_idle_pct  = (mode == IDLE_SENDER)   ? 79 : (mode == IDLE_BOTH) ? 33 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 33 : 0;
        if (pressure) hold_request = 1'b1;
        for (int unsigned n = 0; n < count; n++) begin
            if (pressure && n == count / 2) settle();
            send_item(pick_item(allow_start), 1'b0, none);
        end
    endtask

    initial begin
        width_reg  = 12'd2048;
        col_cnt    = 0;
        row_cnt    = 0;
        for (int r = 0; r < 3; r++) begin
            weight_rows[r] = '0;
            for (int c = 0; c < 3; c++) pix_window[r][c] = '0;
        end
        for (int k = 0; k < MAX_WIDTH; k++) begin
            line_prev[k]  = '0;
            line_prev2[k] = '0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Narrowest line so that windows complete quickly.
        // With the weights still at zero after reset the sum is the partial
        // as it came in, at both bounds and without clipping.
        add_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        add_pixel(1'b1, PIX_MOST_NEG, SUM_MIN);
        add_pixel(1'b0, PIX_MOST_POS, SUM_MAX);
        add_pixel(1'b0, 16'h0001, '0);
        add_pixel(1'b0, 16'hFFFF, 48'h1);
        add_pixel(1'b0, 16'h0100, 48'hFFFF_FFFF_FFFF);
        add_pixel(1'b0, 16'h5A5A, 48'h0000_0040_0000);
        add_pixel(1'b0, 16'hA5A5, 48'hFFFF_FFC0_0000);
        add_pixel(1'b0, PIX_MOST_POS, 48'h1234_5678_9ABC);
        add_checked(PIX_MOST_NEG, SUM_MAX, SUM_MAX, 1'b0);
        add_pixel(1'b0, 16'h00FF, SUM_MAX);
        add_pixel(1'b0, 16'hFF00, SUM_MIN);
        add_checked(16'h1234, SUM_MIN, SUM_MIN, 1'b0);
        // All weights at -2.0 on a fresh plane of most negative pixels: nine
        // positive products on top of the largest partial clip high.
        add_reg(CFG_WEIGHT_TOP, {3{PIX_MOST_NEG}});
        add_reg(CFG_WEIGHT_MID, {3{PIX_MOST_NEG}});
        add_reg(CFG_WEIGHT_BOT, {3{PIX_MOST_NEG}});
        add_pixel(1'b1, PIX_MOST_NEG, '0);
        for (int k = 0; k < 7; k++) add_pixel(1'b0, PIX_MOST_NEG, '0);
        add_checked(PIX_MOST_NEG, SUM_MAX, SUM_MAX, 1'b1);
        // Largest positive weights: nine negative products clip low
        add_reg(CFG_WEIGHT_TOP, {3{PIX_MOST_POS}});
        add_reg(CFG_WEIGHT_MID, {3{PIX_MOST_POS}});
        add_reg(CFG_WEIGHT_BOT, {3{PIX_MOST_POS}});
        add_pixel(1'b0, PIX_MOST_NEG, '0);
        add_pixel(1'b0, PIX_MOST_NEG, '0);
        add_checked(PIX_MOST_NEG, SUM_MIN, SUM_MIN, 1'b1);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == STEP_REG) begin
                settle();
                write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_value);
            end else begin
                send_item(directed_steps[k].item, directed_steps[k].typed,
                          directed_steps[k].result);
            end
        end

        // Random part. Widths 0..2 clamp to three, 4095 to the full line.
        // The phase before the long one takes no plane starts, so the long
        // one runs with the row count saturated and its results climb well
        // into the wide line. The narrow phase after it shrinks the width
        // mid-row.
        run_phase(12'd3,    IDLE_NONE,     50,  1'b1, 1'b0);
        run_phase(12'd0,    IDLE_SENDER,   50,  1'b1, 1'b0);
        run_phase(12'd5,    IDLE_RECEIVER, 50,  1'b1, 1'b0);
        run_phase(12'd1,    IDLE_BOTH,     50,  1'b0, 1'b0);
        run_phase(12'd4095, IDLE_NONE,     300, 1'b0, 1'b0);
        run_phase(12'd2,    IDLE_SENDER,   50,  1'b1, 1'b0);
        run_phase(12'd7,    IDLE_NONE,     100, 1'b1, 1'b1);
        run_phase(WIDTH_W'($urandom_range(4, 40)), IDLE_RECEIVER, 50, 1'b1, 1'b0);
        run_phase(12'd2048, IDLE_BOTH,     50,  1'b1, 1'b0);
        run_phase(12'd4,    IDLE_BOTH,     50,  1'b1, 1'b0);
        run_phase(WIDTH_W'($urandom_range(3, 70)), IDLE_SENDER, 50, 1'b1, 1'b0);
        run_phase(12'd16,   IDLE_RECEIVER, 50,  1'b1, 1'b0);
        run_phase(WIDTH_W'($urandom_range(3, 12)), IDLE_NONE, 50, 1'b1, 1'b0);

        settle();
        if (mismatches == 0)
            $display("conv3x3_stream_accumulate_unit regression: pass");
        else
            $display("conv3x3_stream_accumulate_unit regression: fail");
        $finish;
    end

endmodule
